/* hdl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked at every rising edge outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

/* hdl/dlbc_pkg.sv */
`default_nettype none

package dlbc_pkg;

	// direction register codes
	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	localparam int BYTE_W = 8;

	// level chain restarts here at each block start
	localparam logic LEVEL_START = 1'b1;

	// level pattern of a data byte, chain starts at bit 0 with bit 0 and level 0
	function automatic logic [BYTE_W-1:0] levels_of(input logic [BYTE_W-1:0] b);
		logic              prev_bit;
		logic              level;
		logic [BYTE_W-1:0] code;
		prev_bit = 1'b0;
		level    = 1'b0;
		code     = '0;
		for (int j = 0; j < BYTE_W; j++) begin
			if (b[j] == prev_bit) begin
				level = ~level;
			end
			code[j]  = level;
			prev_bit = b[j];
		end
		return code;
	endfunction

	// inverse of levels_of
	function automatic logic [BYTE_W-1:0] bits_of(input logic [BYTE_W-1:0] code);
		logic              prev_bit;
		logic              prev_level;
		logic [BYTE_W-1:0] b;
		prev_bit   = 1'b0;
		prev_level = 1'b0;
		b          = '0;
		for (int j = 0; j < BYTE_W; j++) begin
			b[j]       = prev_bit ^ 1'b1 ^ (code[j] ^ prev_level);
			prev_bit   = b[j];
			prev_level = code[j];
		end
		return b;
	endfunction

endpackage

`default_nettype wire

/* hdl/dlbc_if.sv */
`default_nettype none

// request channel: one byte with its block start mark
interface dlbc_req_if;
	logic       valid;
	logic       ready;
	logic       block_start;
	logic [7:0] data_byte;

	modport source (output valid, output block_start, output data_byte, input ready);
	modport sink (input valid, input block_start, input data_byte, output ready);
endinterface

// result channel: one coded or decoded byte
interface dlbc_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;

	modport source (output valid, output out_byte, input ready);
	modport sink (input valid, input out_byte, output ready);
endinterface

`default_nettype wire

/* hdl/differential_level_byte_coder.sv */
// Differential level byte coder, encode or decode selected by one register.
// Channels: req (sink) carries block_start and data_byte, res (source)
// carries out_byte; a request moves at a rising edge with valid and ready high.
// Configuration: cfg_we/cfg_wdata write the direction bit (0 encode, 1 decode);
// write it only while no request is in flight.
// Path: an accepted request passes the input register, then the result register,
// before it shows on res. Throughput: one byte per clock while res takes bytes.
// The 8-bit level chain is short combinational logic between the two
// registers, and the chained last level is updated as a byte enters the
// result register, so the next byte sees it in the following cycle.
// Reset: arst_n low clears both stages, sets direction to encode and the
// chained level to 1.
// Stall: when res is not taken, the result register holds, the input
// register holds behind it, and req.ready drops once both are full; it
// stays high while the input register can still move on.
`default_nettype none

`include "assert_macros.svh"

module differential_level_byte_coder (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata,
	dlbc_req_if.sink  req,
	dlbc_res_if.source res
);
	import dlbc_pkg::*;

	logic              direction_q;
	logic              last_level_q;
	logic              valid_s1;
	logic              start_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              valid_s2;
	logic [BYTE_W-1:0] byte_s2;
	logic              advance;
	logic              level;
	logic [BYTE_W-1:0] enc_byte;
	logic [BYTE_W-1:0] dec_byte;
	logic [BYTE_W-1:0] result;
	logic              next_level;

	// handshake: stage 1 moves on when the result register is free or drained
	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign req.ready = !valid_s1 || advance;
	assign res.valid = valid_s2;
	assign res.out_byte = byte_s2;

	// direction register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_ENCODE;
		end else if (cfg_we) begin
			direction_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			start_s1 <= req.block_start;
			byte_s1  <= req.data_byte;
		end
	end

	// level chain in both directions
	always_comb begin
		level    = start_s1 ? LEVEL_START : last_level_q;
		enc_byte = levels_of(byte_s1) ^ {BYTE_W{~level}};
		dec_byte = bits_of(byte_s1 ^ {BYTE_W{~level}});
		if (direction_q == DIR_DECODE) begin
			result     = dec_byte;
			next_level = byte_s1[BYTE_W-1];
		end else begin
			result     = enc_byte;
			next_level = enc_byte[BYTE_W-1];
		end
	end

	// chained level and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= LEVEL_START;
			valid_s2     <= 1'b0;
		end else begin
			if (advance) begin
				last_level_q <= next_level;
			end
			if (!valid_s2 || res.ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance) begin
			byte_s2 <= result;
		end
	end

	// stalled input stage keeps its byte
	`ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !advance,
		valid_s1 && $stable(byte_s1) && $stable(start_s1))
	// encoder chains bit 7 of the code byte it sent
	`ASSERT_NEXT(a_enc_chain, clk, arst_n, advance && direction_q == DIR_ENCODE,
		last_level_q == res.out_byte[BYTE_W-1])
	// decoder chains bit 7 of the received code byte
	`ASSERT_NEXT(a_dec_chain, clk, arst_n, advance && direction_q == DIR_DECODE,
		last_level_q == $past(byte_s1[BYTE_W-1]))
	// an empty input stage always takes a request
	`ASSERT_SAME(a_ready_empty, clk, arst_n, !valid_s1, req.ready)

endmodule

`default_nettype wire
